// ===== rtl/core/dsd_halfrate_decimator_defines.svh =====
// Shared assertion macros for the half-rate DSD decimator.
`ifndef DSD_HALFRATE_DECIMATOR_DEFINES_SVH
`define DSD_HALFRATE_DECIMATOR_DEFINES_SVH

// Clocked check, masked while reset is high.
`define DSDHR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define DSDHR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/dsdhr_pkg.sv =====
package dsdhr_pkg;

  localparam int ChanW      = 3;
  localparam int ByteW      = 8;
  localparam int NibW       = 4;
  localparam int ChanCmpW   = 7;
  localparam int MaxChan    = 1 << ChanW;
  localparam int ChannelsDef = 8;

  localparam logic [1:0] PairZero = 2'b00;
  localparam logic [1:0] PairLo   = 2'b01;
  localparam logic [1:0] PairHi   = 2'b10;
  localparam logic [1:0] PairOnes = 2'b11;

  typedef struct packed {
    logic [ChanW-1:0] channel;
    logic [ByteW-1:0] dsd_byte;
  } dsdhr_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_channel;
    logic [ByteW-1:0] out_byte;
  } dsdhr_out_t;

  // Status of the item sitting in the input register.
  typedef struct packed {
    logic in_range;
    logic emit;
  } dsdhr_step_t;

  typedef struct packed {
    logic [NibW-1:0] nib;
    logic            err;
  } dsdhr_nib_t;

  // Four bit pairs, MSB pair first; the error bit threads through the chain.
  function automatic dsdhr_nib_t byte_to_nibble(logic [ByteW-1:0] b, logic err_in);
    dsdhr_nib_t r;
    logic [1:0] pr;
    logic       e;
    e     = err_in;
    r.nib = '0;
    for (int k = 0; k < NibW; k++) begin
      pr = b[ByteW-1-2*k -: 2];
      r.nib[NibW-1-k] = (pr == PairOnes) || (!e && (pr != PairZero));
      if ((pr == PairLo) || (pr == PairHi)) begin
        e = ~e;
      end
    end
    r.err = e;
    return r;
  endfunction

endpackage

// ===== rtl/core/dsdhr_chan_state.sv =====
module dsdhr_chan_state #(
  parameter int CHANNELS = dsdhr_pkg::ChannelsDef
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dsdhr_pkg::dsdhr_in_t   item,
  input  logic                   advance,
  output dsdhr_pkg::dsdhr_step_t step,
  output dsdhr_pkg::dsdhr_out_t  result
);

  // Channel field is 3 bits, so entries past eight are never addressed.
  localparam int Depth = (CHANNELS < dsdhr_pkg::MaxChan) ? CHANNELS : dsdhr_pkg::MaxChan;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Depth-1:0]          error_bit;
  logic [Depth-1:0]          pair_phase;
  logic [dsdhr_pkg::NibW-1:0] held_nibble [Depth];

  logic [IdxW-1:0]      idx;
  logic                 in_range;
  logic                 err_cur;
  logic                 phase_cur;
  dsdhr_pkg::dsdhr_nib_t conv;
  logic                 wr_en;

  assign idx      = item.channel[IdxW-1:0];
  assign in_range = {{(dsdhr_pkg::ChanCmpW - dsdhr_pkg::ChanW){1'b0}}, item.channel}
                    < dsdhr_pkg::ChanCmpW'(CHANNELS);
  assign err_cur   = in_range ? error_bit[idx]  : 1'b0;
  assign phase_cur = in_range ? pair_phase[idx] : 1'b0;
  assign conv      = dsdhr_pkg::byte_to_nibble(item.dsd_byte, err_cur);
  assign wr_en     = advance && in_range;

  assign step.in_range      = in_range;
  assign step.emit          = in_range && phase_cur;
  assign result.out_channel = item.channel;
  assign result.out_byte    = {held_nibble[idx], conv.nib};

  always_ff @(posedge clk) begin
    if (rst) begin
      error_bit  <= '0;
      pair_phase <= '0;
    end else if (wr_en) begin
      error_bit[idx]  <= conv.err;
      pair_phase[idx] <= ~phase_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !phase_cur) begin
      held_nibble[idx] <= conv.nib;
    end
  end

endmodule

// ===== rtl/core/dsd_halfrate_decimator.sv =====
// Half-rate DSD decimator: takes one channel-tagged DSD byte per cycle (unless
// an emitting byte waits on a stalled result) and, on every second byte of a
// channel, emits one byte (held nibble high, new nibble low). A byte sits in the
// input register and an emitted byte in the result register, around the single
// pass that reads and updates the per-channel error bit, phase and held nibble.
// Items whose channel is not below CHANNELS are dropped without touching state.
module dsd_halfrate_decimator #(
  parameter int CHANNELS = dsdhr_pkg::ChannelsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  dsdhr_pkg::dsdhr_in_t  item,
  output logic                  result_valid,
  input  logic                  result_ready,
  output dsdhr_pkg::dsdhr_out_t result
);

  logic                   s1_valid;
  dsdhr_pkg::dsdhr_in_t   s1_item;
  logic                   s1_advance;
  dsdhr_pkg::dsdhr_step_t step;
  dsdhr_pkg::dsdhr_out_t  result_next;

  // An item that emits nothing may pass even while the result is stalled.
  assign s1_advance = s1_valid && (!step.emit || !result_valid || result_ready);
  assign item_ready = !s1_valid || s1_advance;

  dsdhr_chan_state #(
    .CHANNELS (CHANNELS)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .item    (s1_item),
    .advance (s1_advance),
    .step    (step),
    .result  (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      s1_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance && step.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && step.emit) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/core/dsdhr_checker.sv =====
`include "dsd_halfrate_decimator_defines.svh"

module dsdhr_checker #(
  parameter int CHANNELS = dsdhr_pkg::ChannelsDef
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  item_valid,
  input logic                  item_ready,
  input dsdhr_pkg::dsdhr_in_t  item,
  input logic                  result_valid,
  input logic                  result_ready,
  input dsdhr_pkg::dsdhr_out_t result
);

  logic [dsdhr_pkg::ChanCmpW-1:0] res_chan_wide;

  assign res_chan_wide = {{(dsdhr_pkg::ChanCmpW - dsdhr_pkg::ChanW){1'b0}},
                          result.out_channel};

  `DSDHR_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result), "stalled result changed")
  `DSDHR_ASSERT_RST(a_reset_empty, rst |=> !result_valid, "result valid right after reset")
  `DSDHR_ASSERT(a_chan_range, result_valid |-> (res_chan_wide < dsdhr_pkg::ChanCmpW'(CHANNELS)), "result for out-of-range channel")
  `DSDHR_ASSERT(a_rise_latency, $rose(result_valid) |-> $past(item_valid && item_ready, 2), "result without an input transfer two cycles earlier")
  `DSDHR_ASSERT(a_ready_when_empty, !result_valid |-> item_ready, "input stalled with empty output")

endmodule

bind dsd_halfrate_decimator dsdhr_checker #(.CHANNELS(CHANNELS)) u_dsdhr_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 930;
  localparam int HoldCycles  = 300;

  // Predicts the half-rate byte stream and matches it against what the block emits.
  class decim_scoreboard;
    logic        err_bit     [dsdhr_pkg::MaxChan];
    logic        second_byte [dsdhr_pkg::MaxChan];
    logic [3:0]  held_nib    [dsdhr_pkg::MaxChan];
    dsdhr_pkg::dsdhr_out_t expected_bytes [$];
    int          bytes_in;
    int          bytes_out;
    int          errors;

    function new();
      foreach (err_bit[i]) begin
        err_bit[i]     = 1'b0;
        second_byte[i] = 1'b0;
        held_nib[i]    = '0;
      end
      bytes_in  = 0;
      bytes_out = 0;
      errors    = 0;
    endfunction

    // Walks the four pairs MSB first; the channel's error bit flips on 01 and 10.
    function logic [3:0] fold_byte(logic [2:0] ch, logic [7:0] b);
      logic [3:0] nib;
      logic [1:0] pr;
      nib = '0;
      for (int k = 3; k >= 0; k--) begin
        pr     = b[2*k +: 2];
        nib[k] = (pr == dsdhr_pkg::PairOnes) | (~err_bit[ch] & (pr != dsdhr_pkg::PairZero));
        err_bit[ch] = err_bit[ch] ^ (pr[1] ^ pr[0]);
      end
      return nib;
    endfunction

    function void note_input(dsdhr_pkg::dsdhr_in_t it);
      logic [3:0] nib;
      dsdhr_pkg::dsdhr_out_t want;
      bytes_in++;
      nib = fold_byte(it.channel, it.dsd_byte);
      if (!second_byte[it.channel]) begin
        held_nib[it.channel]    = nib;
        second_byte[it.channel] = 1'b1;
      end else begin
        second_byte[it.channel] = 1'b0;
        want.out_channel = it.channel;
        want.out_byte    = {held_nib[it.channel], nib};
        expected_bytes.push_back(want);
      end
    endfunction

    function void check_result(dsdhr_pkg::dsdhr_out_t got);
      dsdhr_pkg::dsdhr_out_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got ch %0d byte %02h",
                 $time, got.out_channel, got.out_byte);
        return;
      end
      want = expected_bytes.pop_front();
      bytes_out++;
      if (got.out_channel !== want.out_channel) begin
        errors++;
        $display("%0t: out_channel mismatch, expected %0d, got %0d",
                 $time, want.out_channel, got.out_channel);
      end
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte mismatch on ch %0d, expected %02h, got %02h",
                 $time, want.out_channel, want.out_byte, got.out_byte);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  item_valid;
  logic                  item_ready;
  dsdhr_pkg::dsdhr_in_t  item;
  logic                  result_valid;
  logic                  result_ready;
  dsdhr_pkg::dsdhr_out_t result;

  decim_scoreboard sb;
  bit  hold_active = 1'b0;
  bit  hold_done   = 1'b0;
  bit  sender_burst = 1'b0;
  bit  sink_burst   = 1'b0;
  int  cycles = 0;
  int  input_stalls = 0;

  dsd_halfrate_decimator uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout, %0d results still pending", $time, sb.expected_bytes.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Sample mid-cycle: a transfer seen here completes at the next rising edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) sb.note_input(item);
      if (item_valid && !item_ready) input_stalls++;
      if (result_valid && result_ready) sb.check_result(result);
    end
  end

  task automatic send_item(input logic [2:0] ch, input logic [7:0] b);
    int gap;
    gap = (hold_active || sender_burst) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid     <= 1'b1;
    item.channel   <= ch;
    item.dsd_byte  <= b;
    do @(negedge clk); while (!item_ready);
    @(posedge clk);
  endtask

  // Result side: random stalls, burst stretches, and one long hold-off to back up the block.
  initial begin
    int stall;
    result_ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (!hold_done && sb.bytes_out >= 120) begin
        hold_done   = 1'b1;
        hold_active = 1'b1;
        stall       = HoldCycles;
      end else begin
        stall = sink_burst ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      hold_active = 1'b0;
      result_ready <= 1'b1;
      if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      do @(negedge clk); while (!result_valid);
      @(posedge clk);
    end
  end

  initial begin
    logic [2:0] ch;
    logic [7:0] b;
    sb = new();
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zeros, all ones, alternating pairs (error bit toggling), lone 01/10 pairs, mixed 11/00 pairs
    send_item(3'd0, 8'h00); send_item(3'd0, 8'h00);
    send_item(3'd7, 8'hFF); send_item(3'd7, 8'hFF);
    send_item(3'd1, 8'h55); send_item(3'd1, 8'hAA);
    send_item(3'd2, 8'h40); send_item(3'd2, 8'h80);
    send_item(3'd2, 8'hC3); send_item(3'd2, 8'h3C);
    // interleaved channels
    send_item(3'd3, 8'h15); send_item(3'd4, 8'hE8);
    send_item(3'd3, 8'h6A); send_item(3'd4, 8'h97);
    // same channel back to back
    send_item(3'd5, 8'h01); send_item(3'd5, 8'h02);
    send_item(3'd5, 8'h03); send_item(3'd5, 8'h04);
    send_item(3'd6, 8'h7F); send_item(3'd6, 8'hFE);
    send_item(3'd0, 8'hAA); send_item(3'd0, 8'h55);

    ch = 3'd0;
    for (int n = 0; n < RandomItems; n++) begin
      // sticky channel exercises same-channel state hazards in the pipeline
      if ($urandom_range(0, 9) >= 3) ch = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        2:       b = 8'h55;
        3:       b = 8'hAA;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
      send_item(ch, b);
    end
    item_valid <= 1'b0;

    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d DSD bytes over 8 channels, checked %0d half-rate bytes.",
             sb.bytes_in, sb.bytes_out);
    $display("Input held off for %0d cycles, including one %0d-cycle output stall.",
             input_stalls, HoldCycles);
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/dsdhr_pkg.sv
rtl/core/dsdhr_chan_state.sv
rtl/core/dsd_halfrate_decimator.sv
rtl/core/dsdhr_checker.sv
bench/tb_top.sv
